// ===== hw/rtl/dlfc_pkg.sv =====
package dlfc_pkg;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_TX   = 2'd1,
    MODE_CMD  = 2'd2,
    MODE_LOCK = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    CMD_PRIMARY    = 4'd0,
    CMD_BACKUP     = 4'd1,
    CMD_DUAL       = 4'd2,
    CMD_FB_ON      = 4'd3,
    CMD_FB_OFF     = 4'd4,
    CMD_QUERY      = 4'd5,
    CMD_ARM        = 4'd6,
    CMD_STAND_DOWN = 4'd7,
    CMD_REINIT     = 4'd8
  } cmd_t;

  localparam logic [1:0] LINK_PRIMARY = 2'd1;
  localparam logic [1:0] LINK_BACKUP  = 2'd2;

  localparam logic [1:0] RECONF_NONE    = 2'd0;
  localparam logic [1:0] RECONF_PRIMARY = 2'd1;
  localparam logic [1:0] RECONF_BACKUP  = 2'd2;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_REPORT  = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;
  localparam logic [1:0] EV_UNKNOWN = 2'd3;

  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ADDR_W    = 5;

  localparam logic [REG_IDX_W-1:0] REG_RETRY    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HYST     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHECK    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPORT   = 3'd4;

  localparam logic [7:0]  RETRY_RST   = 8'd3;
  localparam logic [31:0] TIMEOUT_RST = 32'd10000;
  localparam logic [31:0] HYST_RST    = 32'd30000;
  localparam logic [31:0] CHECK_RST   = 32'd5000;
  localparam logic [31:0] REPORT_RST  = 32'd30000;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [31:0] failure_timeout_ms;
    logic [31:0] recovery_hysteresis_ms;
    logic [31:0] check_interval_ms;
    logic [31:0] report_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       primary_ok;
    logic       backup_ok;
    logic [3:0] command_code;
    logic       lock_value;
    logic       network_up;
  } item_t;

  typedef struct packed {
    logic [1:0]  link_mode;
    logic [1:0]  reconfigure;
    logic        locked;
    logic        fallback_on;
    logic        armed;
    logic [7:0]  primary_fails;
    logic [7:0]  backup_fails;
    logic        primary_stable;
    logic        backup_stable;
    logic [31:0] primary_age;
    logic [31:0] backup_age;
    logic [1:0]  event_res;
  } res_t;

endpackage

// ===== hw/rtl/dlfc_cfg_regs.sv =====
module dlfc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dlfc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dlfc_pkg::cfg_t              cfg
);

  logic [dlfc_pkg::REG_IDX_W-1:0] idx;
  logic                           wr;

  assign idx    = paddr[dlfc_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit            <= dlfc_pkg::RETRY_RST;
      cfg.failure_timeout_ms     <= dlfc_pkg::TIMEOUT_RST;
      cfg.recovery_hysteresis_ms <= dlfc_pkg::HYST_RST;
      cfg.check_interval_ms      <= dlfc_pkg::CHECK_RST;
      cfg.report_interval_ms     <= dlfc_pkg::REPORT_RST;
    end else if (wr) begin
      unique case (idx)
        dlfc_pkg::REG_RETRY:   cfg.retry_limit            <= pwdata[7:0];
        dlfc_pkg::REG_TIMEOUT: cfg.failure_timeout_ms     <= pwdata;
        dlfc_pkg::REG_HYST:    cfg.recovery_hysteresis_ms <= pwdata;
        dlfc_pkg::REG_CHECK:   cfg.check_interval_ms      <= pwdata;
        dlfc_pkg::REG_REPORT:  cfg.report_interval_ms     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dlfc_pkg::REG_RETRY:   prdata = {24'd0, cfg.retry_limit};
      dlfc_pkg::REG_TIMEOUT: prdata = cfg.failure_timeout_ms;
      dlfc_pkg::REG_HYST:    prdata = cfg.recovery_hysteresis_ms;
      dlfc_pkg::REG_CHECK:   prdata = cfg.check_interval_ms;
      dlfc_pkg::REG_REPORT:  prdata = cfg.report_interval_ms;
      default:               prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/dlfc_core.sv =====
module dlfc_core #(
  parameter int unsigned FCW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  dlfc_pkg::item_t item,
  input  dlfc_pkg::cfg_t  cfg,
  output dlfc_pkg::res_t  res
);

  localparam int unsigned CW = (FCW > 8) ? FCW : 8;
  localparam logic [FCW-1:0] CNT_MAX = {FCW{1'b1}};

  logic [31:0]    time_ms, time_ms_next;
  logic           primary_on, primary_on_next;
  logic           backup_on, backup_on_next;
  logic           fallback_enable, fallback_enable_next;
  logic           mode_lock, mode_lock_next;
  logic           armed_flag, armed_flag_next;
  logic [FCW-1:0] primary_fail_count, primary_fail_count_next;
  logic [FCW-1:0] backup_fail_count, backup_fail_count_next;
  logic [31:0]    primary_last_ok, primary_last_ok_next;
  logic [31:0]    backup_last_ok, backup_last_ok_next;
  logic [1:0]     stable_flags, stable_flags_next;
  logic [31:0]    last_check_time, last_check_time_next;
  logic [31:0]    last_report_time, last_report_time_next;

  logic [31:0] t_inc;
  logic [31:0] p_age_tick;
  logic [CW-1:0] retry_ext;
  logic [CW-1:0] pc_ext, bc_ext;
  logic [1:0]  reconf;
  logic [1:0]  ev;
  logic        p_failed;
  logic        p_recover;

  assign t_inc      = time_ms + 32'd1;
  assign p_age_tick = t_inc - primary_last_ok;
  assign retry_ext  = CW'(cfg.retry_limit);

  always_comb begin
    p_failed  = (CW'(primary_fail_count) >= retry_ext) ||
                ((primary_last_ok != 32'd0) && (p_age_tick > cfg.failure_timeout_ms));
    p_recover = (primary_last_ok != 32'd0) &&
                (p_age_tick > cfg.recovery_hysteresis_ms) && item.network_up;
  end

  always_comb begin
    time_ms_next            = time_ms;
    primary_on_next         = primary_on;
    backup_on_next          = backup_on;
    fallback_enable_next    = fallback_enable;
    mode_lock_next          = mode_lock;
    armed_flag_next         = armed_flag;
    primary_fail_count_next = primary_fail_count;
    backup_fail_count_next  = backup_fail_count;
    primary_last_ok_next    = primary_last_ok;
    backup_last_ok_next     = backup_last_ok;
    stable_flags_next       = stable_flags;
    last_check_time_next    = last_check_time;
    last_report_time_next   = last_report_time;
    reconf                  = dlfc_pkg::RECONF_NONE;
    ev                      = dlfc_pkg::EV_NONE;

    unique case (dlfc_pkg::mode_t'(item.mode))
      dlfc_pkg::MODE_TICK: begin
        time_ms_next = t_inc;
        if ((t_inc - last_check_time) > cfg.check_interval_ms) begin
          last_check_time_next = t_inc;
          if (fallback_enable && !mode_lock) begin
            if (primary_on && !backup_on) begin
              if (p_failed) begin
                primary_on_next = 1'b0;
                backup_on_next  = 1'b1;
                reconf          = dlfc_pkg::RECONF_BACKUP;
              end
            end else if (!primary_on && backup_on) begin
              if (p_recover) begin
                primary_on_next = 1'b1;
                backup_on_next  = 1'b0;
                reconf          = dlfc_pkg::RECONF_PRIMARY;
              end
            end
          end
        end
        if ((t_inc - last_report_time) > cfg.report_interval_ms) begin
          ev                    = dlfc_pkg::EV_REPORT;
          last_report_time_next = t_inc;
        end
      end
      dlfc_pkg::MODE_TX: begin
        if (primary_on) begin
          if (item.primary_ok) begin
            primary_last_ok_next    = time_ms;
            primary_fail_count_next = '0;
          end else if (primary_fail_count != CNT_MAX) begin
            primary_fail_count_next = primary_fail_count + FCW'(1);
          end
        end
        if (backup_on) begin
          if (item.backup_ok) begin
            backup_last_ok_next    = time_ms;
            backup_fail_count_next = '0;
          end else if (backup_fail_count != CNT_MAX) begin
            backup_fail_count_next = backup_fail_count + FCW'(1);
          end
        end
        stable_flags_next[0] = !primary_on || (CW'(primary_fail_count_next) < retry_ext);
        stable_flags_next[1] = !backup_on || (CW'(backup_fail_count_next) < retry_ext);
      end
      dlfc_pkg::MODE_CMD: begin
        if (mode_lock && (item.command_code != dlfc_pkg::CMD_ARM) &&
            (item.command_code != dlfc_pkg::CMD_STAND_DOWN) &&
            (item.command_code != dlfc_pkg::CMD_REINIT)) begin
          ev = dlfc_pkg::EV_REJECT;
        end else begin
          unique case (item.command_code)
            dlfc_pkg::CMD_PRIMARY: begin
              primary_on_next = 1'b1;
              backup_on_next  = 1'b0;
              if (!(primary_on && !backup_on)) reconf = dlfc_pkg::RECONF_PRIMARY;
            end
            dlfc_pkg::CMD_BACKUP: begin
              primary_on_next = 1'b0;
              backup_on_next  = 1'b1;
              if (!(backup_on && !primary_on)) reconf = dlfc_pkg::RECONF_BACKUP;
            end
            dlfc_pkg::CMD_DUAL: begin
              primary_on_next = 1'b1;
              backup_on_next  = 1'b1;
            end
            dlfc_pkg::CMD_FB_ON:  fallback_enable_next = 1'b1;
            dlfc_pkg::CMD_FB_OFF: fallback_enable_next = 1'b0;
            dlfc_pkg::CMD_QUERY:  ev = dlfc_pkg::EV_REPORT;
            dlfc_pkg::CMD_ARM:    armed_flag_next = 1'b1;
            dlfc_pkg::CMD_STAND_DOWN: begin
              armed_flag_next = 1'b0;
              mode_lock_next  = 1'b0;
            end
            dlfc_pkg::CMD_REINIT: begin
              primary_on_next         = 1'b1;
              backup_on_next          = 1'b0;
              fallback_enable_next    = 1'b1;
              mode_lock_next          = 1'b0;
              primary_fail_count_next = '0;
              backup_fail_count_next  = '0;
              primary_last_ok_next    = 32'd0;
              backup_last_ok_next     = 32'd0;
              stable_flags_next       = 2'b00;
              last_check_time_next    = time_ms;
              last_report_time_next   = time_ms;
            end
            default: ev = dlfc_pkg::EV_UNKNOWN;
          endcase
        end
      end
      dlfc_pkg::MODE_LOCK: mode_lock_next = item.lock_value;
      default: ;
    endcase
  end

  always_comb begin
    pc_ext              = CW'(primary_fail_count_next);
    bc_ext              = CW'(backup_fail_count_next);
    res.link_mode       = {backup_on_next, primary_on_next};
    res.reconfigure     = reconf;
    res.locked          = mode_lock_next;
    res.fallback_on     = fallback_enable_next;
    res.armed           = armed_flag_next;
    res.primary_fails   = pc_ext[7:0];
    res.backup_fails    = bc_ext[7:0];
    res.primary_stable  = stable_flags_next[0];
    res.backup_stable   = stable_flags_next[1];
    res.primary_age     = (primary_last_ok_next != 32'd0) ?
                          (time_ms_next - primary_last_ok_next) : 32'd0;
    res.backup_age      = (backup_last_ok_next != 32'd0) ?
                          (time_ms_next - backup_last_ok_next) : 32'd0;
    res.event_res       = ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms            <= 32'd0;
      primary_on         <= 1'b1;
      backup_on          <= 1'b0;
      fallback_enable    <= 1'b1;
      mode_lock          <= 1'b0;
      armed_flag         <= 1'b0;
      primary_fail_count <= '0;
      backup_fail_count  <= '0;
      primary_last_ok    <= 32'd0;
      backup_last_ok     <= 32'd0;
      stable_flags       <= 2'b00;
      last_check_time    <= 32'd0;
      last_report_time   <= 32'd0;
    end else if (fire) begin
      time_ms            <= time_ms_next;
      primary_on         <= primary_on_next;
      backup_on          <= backup_on_next;
      fallback_enable    <= fallback_enable_next;
      mode_lock          <= mode_lock_next;
      armed_flag         <= armed_flag_next;
      primary_fail_count <= primary_fail_count_next;
      backup_fail_count  <= backup_fail_count_next;
      primary_last_ok    <= primary_last_ok_next;
      backup_last_ok     <= backup_last_ok_next;
      stable_flags       <= stable_flags_next;
      last_check_time    <= last_check_time_next;
      last_report_time   <= last_report_time_next;
    end
  end

endmodule

// ===== hw/rtl/dual_link_failover_controller_top.sv =====
// a request is captured in the input register and its result in the result register
// throughput: one request per cycle while the output is not stalled; the state update
// for one request is combinational logic between the input and result registers
// reset: synchronous, active high; link state returns to primary only,
// counters and timestamps clear, and the control registers take their defaults
module dual_link_failover_controller_top #(
  parameter int unsigned FAIL_COUNT_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dlfc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic                        primary_ok,
  input  logic                        backup_ok,
  input  logic [3:0]                  command_code,
  input  logic                        lock_value,
  input  logic                        network_up,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  link_mode,
  output logic [1:0]                  reconfigure,
  output logic                        locked,
  output logic                        fallback_on,
  output logic                        armed,
  output logic [7:0]                  primary_fails,
  output logic [7:0]                  backup_fails,
  output logic                        primary_stable,
  output logic                        backup_stable,
  output logic [31:0]                 primary_age,
  output logic [31:0]                 backup_age,
  output logic [1:0]                  event_res
);

  dlfc_pkg::cfg_t  cfg;
  dlfc_pkg::item_t s1_item;
  dlfc_pkg::res_t  res;
  dlfc_pkg::res_t  res_q;
  logic            s1_valid;
  logic            adv;

  dlfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dlfc_core #(
    .FCW (FAIL_COUNT_WIDTH)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (adv),
    .item (s1_item),
    .cfg  (cfg),
    .res  (res)
  );

  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item.mode         <= mode;
      s1_item.primary_ok   <= primary_ok;
      s1_item.backup_ok    <= backup_ok;
      s1_item.command_code <= command_code;
      s1_item.lock_value   <= lock_value;
      s1_item.network_up   <= network_up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign link_mode      = res_q.link_mode;
  assign reconfigure    = res_q.reconfigure;
  assign locked         = res_q.locked;
  assign fallback_on    = res_q.fallback_on;
  assign armed          = res_q.armed;
  assign primary_fails  = res_q.primary_fails;
  assign backup_fails   = res_q.backup_fails;
  assign primary_stable = res_q.primary_stable;
  assign backup_stable  = res_q.backup_stable;
  assign primary_age    = res_q.primary_age;
  assign backup_age     = res_q.backup_age;
  assign event_res      = res_q.event_res;

endmodule

// ===== hw/rtl/dlfc_checker.sv =====
module dlfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] link_mode,
  input logic [1:0] reconfigure,
  input logic       locked,
  input logic [1:0] event_res
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(link_mode) && $stable(reconfigure))
    else $error("stalled result changed");

  // a reconfigure request always matches the resulting single-link mode
  a_reconf_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reconfigure != dlfc_pkg::RECONF_NONE) |->
      ((reconfigure == dlfc_pkg::RECONF_PRIMARY) && (link_mode == dlfc_pkg::LINK_PRIMARY)) ||
      ((reconfigure == dlfc_pkg::RECONF_BACKUP) && (link_mode == dlfc_pkg::LINK_BACKUP)))
    else $error("reconfigure does not match link mode");

  // a rejected command leaves the lock set
  a_reject_locked: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == dlfc_pkg::EV_REJECT) |-> locked)
    else $error("rejection reported while unlocked");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind dual_link_failover_controller_top dlfc_checker u_dlfc_checker (.*);

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] CMD_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] CMD_UNKNOWN_HI = 4'd15;
  localparam logic [dlfc_pkg::REG_IDX_W-1:0] REG_UNUSED = 3'd5;
  localparam int PHASES = 8;
  localparam int PHASE_REQS = 70;
  localparam int SAT_BURST = 258;
  localparam int HOLD_CYCLES = 60;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [dlfc_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    mode;
  logic                          primary_ok;
  logic                          backup_ok;
  logic [3:0]                    command_code;
  logic                          lock_value;
  logic                          network_up;
  logic                          out_valid;
  logic                          out_stall;
  logic [1:0]                    link_mode;
  logic [1:0]                    reconfigure;
  logic                          locked;
  logic                          fallback_on;
  logic                          armed;
  logic [7:0]                    primary_fails;
  logic [7:0]                    backup_fails;
  logic                          primary_stable;
  logic                          backup_stable;
  logic [31:0]                   primary_age;
  logic [31:0]                   backup_age;
  logic [1:0]                    event_res;

  dual_link_failover_controller_top DUT (.*);

  // link state mirror
  dlfc_pkg::cfg_t limits;
  logic [31:0] now_ms;
  logic        pri_on, bak_on, fb_en, lock_q, arm_q;
  logic [7:0]  pri_fails, bak_fails;
  logic [31:0] pri_last, bak_last;
  logic [1:0]  stable_q;
  logic [31:0] last_eval, last_report;

  dlfc_pkg::res_t  pending_status[$];
  dlfc_pkg::item_t plan_req[$];
  bit              plan_typed[$];
  dlfc_pkg::res_t  plan_want[$];

  int errors = 0;
  int n_reqs = 0;
  int n_switch = 0;
  int n_report = 0;
  int n_reject = 0;
  int n_unknown = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int pri_quality = 50;

  function automatic logic [1:0] select_primary();
    logic was;
    was = pri_on && !bak_on;
    pri_on = 1'b1;
    bak_on = 1'b0;
    return was ? dlfc_pkg::RECONF_NONE : dlfc_pkg::RECONF_PRIMARY;
  endfunction

  function automatic logic [1:0] select_backup();
    logic was;
    was = bak_on && !pri_on;
    pri_on = 1'b0;
    bak_on = 1'b1;
    return was ? dlfc_pkg::RECONF_NONE : dlfc_pkg::RECONF_BACKUP;
  endfunction

  function automatic void restore_links();
    pri_on = 1'b1;
    bak_on = 1'b0;
    fb_en = 1'b1;
    lock_q = 1'b0;
    pri_fails = '0;
    bak_fails = '0;
    pri_last = '0;
    bak_last = '0;
    stable_q = '0;
    last_eval = now_ms;
    last_report = now_ms;
  endfunction

  function automatic dlfc_pkg::res_t apply_request(dlfc_pkg::item_t it);
    dlfc_pkg::res_t r;
    logic [1:0] rc;
    logic [1:0] ev;
    rc = dlfc_pkg::RECONF_NONE;
    ev = dlfc_pkg::EV_NONE;
    case (it.mode)
      dlfc_pkg::MODE_TICK: begin
        now_ms = now_ms + 32'd1;
        if (now_ms - last_eval > limits.check_interval_ms) begin
          if (fb_en && !lock_q) begin
            if (pri_on && !bak_on) begin
              if (pri_fails >= limits.retry_limit ||
                  (pri_last != 0 && now_ms - pri_last > limits.failure_timeout_ms))
                rc = select_backup();
            end else if (!pri_on && bak_on) begin
              if (pri_last != 0 && now_ms - pri_last > limits.recovery_hysteresis_ms &&
                  it.network_up)
                rc = select_primary();
            end
          end
          last_eval = now_ms;
        end
        if (now_ms - last_report > limits.report_interval_ms) begin
          ev = dlfc_pkg::EV_REPORT;
          last_report = now_ms;
        end
      end
      dlfc_pkg::MODE_TX: begin
        if (pri_on) begin
          if (it.primary_ok) begin
            pri_last = now_ms;
            pri_fails = '0;
          end else if (pri_fails != 8'hFF) begin
            pri_fails = pri_fails + 8'd1;
          end
        end
        if (bak_on) begin
          if (it.backup_ok) begin
            bak_last = now_ms;
            bak_fails = '0;
          end else if (bak_fails != 8'hFF) begin
            bak_fails = bak_fails + 8'd1;
          end
        end
        stable_q[0] = !pri_on || pri_fails < limits.retry_limit;
        stable_q[1] = !bak_on || bak_fails < limits.retry_limit;
      end
      dlfc_pkg::MODE_CMD: begin
        if (lock_q && it.command_code != dlfc_pkg::CMD_ARM &&
            it.command_code != dlfc_pkg::CMD_STAND_DOWN &&
            it.command_code != dlfc_pkg::CMD_REINIT) begin
          ev = dlfc_pkg::EV_REJECT;
        end else begin
          case (it.command_code)
            dlfc_pkg::CMD_PRIMARY: rc = select_primary();
            dlfc_pkg::CMD_BACKUP:  rc = select_backup();
            dlfc_pkg::CMD_DUAL: begin
              pri_on = 1'b1;
              bak_on = 1'b1;
            end
            dlfc_pkg::CMD_FB_ON:   fb_en = 1'b1;
            dlfc_pkg::CMD_FB_OFF:  fb_en = 1'b0;
            dlfc_pkg::CMD_QUERY:   ev = dlfc_pkg::EV_REPORT;
            dlfc_pkg::CMD_ARM:     arm_q = 1'b1;
            dlfc_pkg::CMD_STAND_DOWN: begin
              arm_q = 1'b0;
              lock_q = 1'b0;
            end
            dlfc_pkg::CMD_REINIT:  restore_links();
            default:               ev = dlfc_pkg::EV_UNKNOWN;
          endcase
        end
      end
      default: lock_q = it.lock_value;
    endcase
    r.link_mode = {bak_on, pri_on};
    r.reconfigure = rc;
    r.locked = lock_q;
    r.fallback_on = fb_en;
    r.armed = arm_q;
    r.primary_fails = pri_fails;
    r.backup_fails = bak_fails;
    r.primary_stable = stable_q[0];
    r.backup_stable = stable_q[1];
    r.primary_age = (pri_last != 0) ? now_ms - pri_last : 32'd0;
    r.backup_age = (bak_last != 0) ? now_ms - bak_last : 32'd0;
    r.event_res = ev;
    return r;
  endfunction

  function automatic dlfc_pkg::item_t req(logic [1:0] m, bit p, bit b, logic [3:0] c, bit lk,
                                          bit net);
    dlfc_pkg::item_t it;
    it.mode = m;
    it.primary_ok = p;
    it.backup_ok = b;
    it.command_code = c;
    it.lock_value = lk;
    it.network_up = net;
    return it;
  endfunction

  // link state after reset once a transfer has set both stable flags, with only lock, arm and event varying
  function automatic dlfc_pkg::res_t base_view(bit lk, bit arm, logic [1:0] ev);
    dlfc_pkg::res_t r;
    r = '0;
    r.link_mode = dlfc_pkg::LINK_PRIMARY;
    r.locked = lk;
    r.fallback_on = 1'b1;
    r.armed = arm;
    r.primary_stable = 1'b1;
    r.backup_stable = 1'b1;
    r.event_res = ev;
    return r;
  endfunction

  function automatic dlfc_pkg::item_t random_request();
    dlfc_pkg::item_t it;
    int unsigned pick;
    it = dlfc_pkg::item_t'(10'($urandom_range(1023)));
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.mode = dlfc_pkg::MODE_TICK;
    end else if (pick < 75) begin
      it.mode = dlfc_pkg::MODE_TX;
      it.primary_ok = $urandom_range(99) < pri_quality;
      it.backup_ok = $urandom_range(99) < 80;
    end else if (pick < 90) begin
      it.mode = dlfc_pkg::MODE_CMD;
      if ($urandom_range(99) < 85)
        it.command_code = 4'($urandom_range(dlfc_pkg::CMD_REINIT));
      else
        it.command_code = 4'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
    end else begin
      it.mode = dlfc_pkg::MODE_LOCK;
      it.lock_value = $urandom_range(99) < 35;
    end
    it.network_up = $urandom_range(99) < 75;
    return it;
  endfunction

  function automatic string field_diffs(dlfc_pkg::res_t w, dlfc_pkg::res_t g);
    string s;
    s = "";
    if (w.link_mode !== g.link_mode)
      s = {s, $sformatf(" link_mode %0d/%0d", w.link_mode, g.link_mode)};
    if (w.reconfigure !== g.reconfigure)
      s = {s, $sformatf(" reconfigure %0d/%0d", w.reconfigure, g.reconfigure)};
    if (w.locked !== g.locked)
      s = {s, $sformatf(" locked %0d/%0d", w.locked, g.locked)};
    if (w.fallback_on !== g.fallback_on)
      s = {s, $sformatf(" fallback_on %0d/%0d", w.fallback_on, g.fallback_on)};
    if (w.armed !== g.armed)
      s = {s, $sformatf(" armed %0d/%0d", w.armed, g.armed)};
    if (w.primary_fails !== g.primary_fails)
      s = {s, $sformatf(" primary_fails %0d/%0d", w.primary_fails, g.primary_fails)};
    if (w.backup_fails !== g.backup_fails)
      s = {s, $sformatf(" backup_fails %0d/%0d", w.backup_fails, g.backup_fails)};
    if (w.primary_stable !== g.primary_stable)
      s = {s, $sformatf(" primary_stable %0d/%0d", w.primary_stable, g.primary_stable)};
    if (w.backup_stable !== g.backup_stable)
      s = {s, $sformatf(" backup_stable %0d/%0d", w.backup_stable, g.backup_stable)};
    if (w.primary_age !== g.primary_age)
      s = {s, $sformatf(" primary_age %0d/%0d", w.primary_age, g.primary_age)};
    if (w.backup_age !== g.backup_age)
      s = {s, $sformatf(" backup_age %0d/%0d", w.backup_age, g.backup_age)};
    if (w.event_res !== g.event_res)
      s = {s, $sformatf(" event_res %0d/%0d", w.event_res, g.event_res)};
    return s;
  endfunction

  function automatic void flag_mismatch(string msg);
    errors++;
    if (errors <= 10)
      $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  task automatic apb_write(logic [dlfc_pkg::REG_IDX_W-1:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_limits(dlfc_pkg::cfg_t c);
    apb_write(dlfc_pkg::REG_RETRY, {24'd0, c.retry_limit});
    apb_write(dlfc_pkg::REG_TIMEOUT, c.failure_timeout_ms);
    apb_write(dlfc_pkg::REG_HYST, c.recovery_hysteresis_ms);
    apb_write(dlfc_pkg::REG_CHECK, c.check_interval_ms);
    apb_write(dlfc_pkg::REG_REPORT, c.report_interval_ms);
    limits = c;
  endtask

  task automatic offer(dlfc_pkg::item_t it, bit typed, dlfc_pkg::res_t want);
    dlfc_pkg::res_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.mode;
    primary_ok <= it.primary_ok;
    backup_ok <= it.backup_ok;
    command_code <= it.command_code;
    lock_value <= it.lock_value;
    network_up <= it.network_up;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = apply_request(it);
    if (typed)
      e = want;
    n_reqs++;
    if (e.reconfigure != dlfc_pkg::RECONF_NONE) n_switch++;
    if (e.event_res == dlfc_pkg::EV_REPORT) n_report++;
    if (e.event_res == dlfc_pkg::EV_REJECT) n_reject++;
    if (e.event_res == dlfc_pkg::EV_UNKNOWN) n_unknown++;
    pending_status.push_back(e);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (pending_status.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic add_row(dlfc_pkg::item_t it, bit typed, dlfc_pkg::res_t want);
    plan_req.push_back(it);
    plan_typed.push_back(typed);
    plan_want.push_back(want);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // output side: random stall plus a single long hold
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    dlfc_pkg::res_t got;
    dlfc_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {link_mode, reconfigure, locked, fallback_on, armed, primary_fails,
             backup_fails, primary_stable, backup_stable, primary_age, backup_age,
             event_res};
      if (pending_status.size() == 0) begin
        flag_mismatch($sformatf("status with nothing pending: %h", got));
      end else begin
        want = pending_status.pop_front();
        if (got !== want)
          flag_mismatch($sformatf("status mismatch (exp/got):%s", field_diffs(want, got)));
      end
    end
  end

  initial begin
    dlfc_pkg::cfg_t  c;
    dlfc_pkg::item_t it;
    int quality_pick;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    mode = dlfc_pkg::MODE_TICK;
    primary_ok = 1'b0;
    backup_ok = 1'b0;
    command_code = '0;
    lock_value = 1'b0;
    network_up = 1'b0;

    limits = '{dlfc_pkg::RETRY_RST, dlfc_pkg::TIMEOUT_RST, dlfc_pkg::HYST_RST,
               dlfc_pkg::CHECK_RST, dlfc_pkg::REPORT_RST};
    now_ms = '0;
    arm_q = 1'b0;
    restore_links();

    // success at time zero reads as never, unknown commands, lock and arm/disarm behavior
    add_row(req(dlfc_pkg::MODE_TX, 1, 1, CMD_UNKNOWN_HI, 1, 0), 1,
            base_view(0, 0, dlfc_pkg::EV_NONE));
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, CMD_UNKNOWN_HI, 0, 1), 1,
            base_view(0, 0, dlfc_pkg::EV_UNKNOWN));
    add_row(req(dlfc_pkg::MODE_LOCK, 1, 0, dlfc_pkg::CMD_PRIMARY, 1, 1), 1,
            base_view(1, 0, dlfc_pkg::EV_NONE));
    add_row(req(dlfc_pkg::MODE_CMD, 0, 1, dlfc_pkg::CMD_PRIMARY, 0, 0), 1,
            base_view(1, 0, dlfc_pkg::EV_REJECT));
    add_row(req(dlfc_pkg::MODE_CMD, 1, 1, CMD_UNKNOWN_LO, 1, 1), 1,
            base_view(1, 0, dlfc_pkg::EV_REJECT));
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_ARM, 0, 0), 1,
            base_view(1, 1, dlfc_pkg::EV_NONE));
    add_row(req(dlfc_pkg::MODE_CMD, 1, 0, dlfc_pkg::CMD_STAND_DOWN, 1, 0), 1,
            base_view(0, 0, dlfc_pkg::EV_NONE));
    add_row(req(dlfc_pkg::MODE_TICK, 0, 0, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_TX, 1, 0, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_QUERY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_BACKUP, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_BACKUP, 0, 0), 0, '0);
    add_row(req(dlfc_pkg::MODE_TX, 0, 0, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_DUAL, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_TX, 0, 1, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_FB_OFF, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_FB_ON, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_TX, 0, 1, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_TX, 0, 1, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_TX, 0, 1, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_ARM, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_REINIT, 0, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_TICK, 1, 1, CMD_UNKNOWN_HI, 1, 1), 0, '0);
    add_row(req(dlfc_pkg::MODE_LOCK, 0, 0, dlfc_pkg::CMD_PRIMARY, 0, 0), 0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_req[i])
      offer(plan_req[i], plan_typed[i], plan_want[i]);
    in_valid <= 1'b0;
    drain();

    for (int p = 0; p < PHASES; p++) begin
      c.retry_limit = 8'($urandom_range(8, 1));
      c.failure_timeout_ms = $urandom_range(60, 2);
      c.recovery_hysteresis_ms = $urandom_range(80, 2);
      c.check_interval_ms = $urandom_range(12, 1);
      c.report_interval_ms = $urandom_range(60, 1);
      if (p == 0)
        c = '{8'd1, 32'd1, 32'd1, 32'd1, 32'd1};
      if (p == 1)
        c = '{8'hFF, '1, '1, '1, '1};
      if (p == 2)
        c.retry_limit = 8'd0;
      program_limits(c);
      if (p == 2)
        apb_write(REG_UNUSED, $urandom);

      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      if (p == 0)
        hold_left = HOLD_CYCLES;

      // failure counters driven into saturation on both links
      if (p == 1) begin
        offer(req(dlfc_pkg::MODE_LOCK, 0, 0, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
        offer(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_FB_OFF, 0, 1), 0, '0);
        offer(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_DUAL, 0, 1), 0, '0);
        for (int k = 0; k < SAT_BURST; k++) begin
          it = random_request();
          it.mode = dlfc_pkg::MODE_TX;
          it.primary_ok = 1'b0;
          it.backup_ok = 1'b0;
          offer(it, 0, '0);
        end
        offer(req(dlfc_pkg::MODE_TX, 1, 1, dlfc_pkg::CMD_PRIMARY, 0, 1), 0, '0);
        offer(req(dlfc_pkg::MODE_CMD, 0, 0, dlfc_pkg::CMD_FB_ON, 0, 1), 0, '0);
      end

      for (int k = 0; k < PHASE_REQS; k++) begin
        if ($urandom_range(24) == 0) begin
          quality_pick = $urandom_range(2);
          pri_quality = (quality_pick == 0) ? 5 : (quality_pick == 1) ? 50 : 95;
        end
        offer(random_request(), 0, '0);
      end
      in_valid <= 1'b0;
      drain();
    end

    if (pending_status.size() != 0)
      flag_mismatch($sformatf("%0d status results never arrived", pending_status.size()));

    $display("covered %0d requests over %0d limit settings, idle/stall mixes and an output hold",
             n_reqs, PHASES + 1);
    $display("saw %0d link switches, %0d status reports, %0d lock rejections, %0d unknown commands",
             n_switch, n_report, n_reject, n_unknown);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dlfc_pkg.sv
hw/rtl/dlfc_cfg_regs.sv
hw/rtl/dlfc_core.sv
hw/rtl/dual_link_failover_controller_top.sv
hw/rtl/dlfc_checker.sv
tb/tb.sv
